FILE: sv/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and tables of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QUEUE_DEPTH      = 4;
  // Quotient bits produced by the divider; larger quotients are caught up front.
  localparam int DIV_STEPS        = 33;
  localparam int SQRT_STEPS       = 32;
  localparam int ANGLE_W          = 35;
  localparam logic signed [ANGLE_W-1:0] PI_Q30 = 35'sd3373259426;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_MUL   = 3'd1,
    CMD_DIV   = 3'd2,
    CMD_PAR   = 3'd3,
    CMD_MAG   = 3'd4,
    CMD_PHASE = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_SAT     = 2'd2
  } status_e;

  // One classified job as it travels from the front end to the back end.
  typedef struct packed {
    cmd_e                       cmd;
    logic                       ov;
    logic                       dz;
    logic signed [31:0]         res_re;
    logic signed [31:0]         res_im;
    logic                       re_neg;
    logic                       im_neg;
    logic                       re_big;
    logic                       im_big;
    logic [63:0]                rem_re;
    logic [63:0]                rem_im;
    logic [DIV_STEPS-1:0]       low_re;
    logic [DIV_STEPS-1:0]       low_im;
    logic [63:0]                den;
    logic signed [ANGLE_W-1:0]  cx;
    logic signed [ANGLE_W-1:0]  cy;
    logic signed [ANGLE_W-1:0]  cz;
    logic                       czero;
  } cau_job_t;

  // Saturates a wide signed value to 32 bits; the top bit flags saturation.
  function automatic logic [32:0] sat_w65(input logic signed [64:0] v);
    if (v > 65'sd2147483647) begin
      return {1'b1, 32'h7fffffff};
    end else if (v < -65'sd2147483648) begin
      return {1'b1, 32'h80000000};
    end
    return {1'b0, v[31:0]};
  endfunction

  // atan(2^-i) in Q30, truncated.
  function automatic logic signed [ANGLE_W-1:0] atan_q30(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h3243F6A8;
      1:  a = 32'h1DAC6705;
      2:  a = 32'h0FADBAFC;
      3:  a = 32'h07F56EA6;
      4:  a = 32'h03FEAB76;
      5:  a = 32'h01FFD55B;
      6:  a = 32'h00FFFAAA;
      7:  a = 32'h007FFF55;
      8:  a = 32'h003FFFEA;
      9:  a = 32'h001FFFFD;
      10: a = 32'h000FFFFF;
      11: a = 32'h0007FFFF;
      12: a = 32'h0003FFFF;
      13: a = 32'h0001FFFF;
      14: a = 32'h0000FFFF;
      15: a = 32'h00007FFF;
      16: a = 32'h00003FFF;
      17: a = 32'h00001FFF;
      18: a = 32'h00000FFF;
      19: a = 32'h000007FF;
      20: a = 32'h000003FF;
      21: a = 32'h000001FF;
      22: a = 32'h000000FF;
      23: a = 32'h0000007F;
      24: a = 32'h0000003F;
      25: a = 32'h0000001F;
      26: a = 32'h0000000F;
      27: a = 32'h00000007;
      28: a = 32'h00000003;
      29: a = 32'h00000001;
      default: a = 32'h0;
    endcase
    return $signed({3'b000, a});
  endfunction

endpackage

FILE: sv/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, multiply, divide, parallel combination, magnitude and phase.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one command per transaction: tuser holds the
// command and tdata holds both complex operands. The master stream returns
// one transaction per command: tdata holds the complex result and tuser the
// status (ok, division by zero, saturated).
// Every command takes the same path, so results leave in order. One
// transaction per cycle is sustained in both directions while the receiver
// takes results at once. The iteration pipeline follows the divider: one
// quotient bit per stage over 33 stages; the square root and CORDIC steps
// share those stages.
// A four-entry job queue separates the six-stage front end from the
// iteration pipeline. When the receiver stalls, the back end holds, the
// queue fills, and then the front end lowers s_axis_tready_o.
// Reset clears all valid flags and queue pointers; nothing else needs it.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,  // a_re, a_im, b_re, b_im
  input  logic [2:0]   s_axis_tuser_i,  // command
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o,  // res_re, res_im
  output logic [1:0]   m_axis_tuser_o   // status
);

  logic     push, full, pop, empty;
  cau_job_t job_in, job_out;

  cau_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .cmd_i     (s_axis_tuser_i),
    .a_re_i    (s_axis_tdata_i[31:0]),
    .a_im_i    (s_axis_tdata_i[63:32]),
    .b_re_i    (s_axis_tdata_i[95:64]),
    .b_im_i    (s_axis_tdata_i[127:96]),
    .push_o    (push),
    .full_i    (full),
    .job_o     (job_in)
  );

  cau_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .job_o  (job_out)
  );

  cau_back #(
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_status_o(m_axis_tuser_o)
  );

endmodule

FILE: sv/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Accepts operand transactions, forms sums and products, and prepares each
// job (divider operands, square root radicand, folded CORDIC vector).
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  output logic               push_o,
  input  logic               full_i,
  output cau_job_t           job_o
);

  localparam int CMPW = 64 + DIV_STEPS - FRAC_BITS;

  logic en;
  logic [6:1] v_q;

  // Stage 1: operand registers.
  cmd_e cmd1_q;
  logic signed [31:0] ar1_q, ai1_q, br1_q, bi1_q;
  // Stage 2: products and sums of a and b.
  cmd_e cmd2_q;
  logic signed [63:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [32:0] sr2_q, si2_q;
  logic signed [31:0] ar2_q, ai2_q, br2_q, bi2_q;
  // Stage 3: saturated add and multiply, divider operands chosen.
  cmd_e cmd3_q, cmd4_q, cmd5_q, cmd6_q;
  logic signed [31:0] xr3_q, xi3_q, yr3_q, yi3_q;
  logic signed [31:0] rre3_q, rim3_q, rre4_q, rim4_q, rre5_q, rim5_q, rre6_q, rim6_q;
  logic ov3_q, ov4_q, ov5_q, ov6_q;
  logic signed [ANGLE_W-1:0] cx3_q, cy3_q, cz3_q, cx4_q, cy4_q, cz4_q;
  logic signed [ANGLE_W-1:0] cx5_q, cy5_q, cz5_q, cx6_q, cy6_q, cz6_q;
  logic cz3z_q, cz4z_q, cz5z_q, cz6z_q;
  // Stage 4: products of the divider operands.
  logic signed [63:0] q1_q, q2_q, q3_q, q4_q, d1_q, d2_q;
  // Stage 5: numerators and denominator.
  logic signed [64:0] nre5_q, nim5_q;
  logic [63:0] den5_q, den6_q;
  // Stage 6: magnitudes and signs.
  logic [63:0] mre6_q, mim6_q;
  logic nre6_q, nim6_q, dz6_q;

  assign en         = !v_q[6] || !full_i;
  assign in_ready_o = en;
  assign push_o     = v_q[6] && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[5:1], in_valid_i};
    end
  end

  // Stage 3 logic.
  logic signed [64:0] mre_w, mim_w;
  logic [32:0] mre_s, mim_s, are_s, aim_s;
  logic signed [31:0] xr_d, xi_d, yr_d, yi_d, rre_d, rim_d;
  logic ov_d;
  logic signed [ANGLE_W-1:0] cx_d, cy_d, cz_d;

  always_comb begin
    mre_w = (65'(p1_q) - 65'(p2_q)) >>> FRAC_BITS;
    mim_w = (65'(p3_q) + 65'(p4_q)) >>> FRAC_BITS;
    mre_s = sat_w65(mre_w);
    mim_s = sat_w65(mim_w);
    are_s = sat_w65(65'(sr2_q));
    aim_s = sat_w65(65'(si2_q));
    xr_d  = ar2_q;
    xi_d  = ai2_q;
    yr_d  = br2_q;
    yi_d  = bi2_q;
    rre_d = '0;
    rim_d = '0;
    ov_d  = 1'b0;
    case (cmd2_q)
      CMD_ADD: begin
        rre_d = are_s[31:0];
        rim_d = aim_s[31:0];
        ov_d  = are_s[32] | aim_s[32];
      end
      CMD_MUL: begin
        rre_d = mre_s[31:0];
        rim_d = mim_s[31:0];
        ov_d  = mre_s[32] | mim_s[32];
      end
      CMD_PAR: begin
        xr_d = mre_s[31:0];
        xi_d = mim_s[31:0];
        yr_d = are_s[31:0];
        yi_d = aim_s[31:0];
        ov_d = mre_s[32] | mim_s[32] | are_s[32] | aim_s[32];
      end
      CMD_MAG: begin
        // The denominator path then yields re^2 + im^2.
        yr_d = ar2_q;
        yi_d = ai2_q;
      end
      default: ;
    endcase
    // A vector in the left half plane is turned by pi before the iterations.
    cx_d = ANGLE_W'(ar2_q);
    cy_d = ANGLE_W'(ai2_q);
    cz_d = '0;
    if (ar2_q < 0) begin
      cz_d = (ai2_q >= 0) ? PI_Q30 : -PI_Q30;
      cx_d = -ANGLE_W'(ar2_q);
      cy_d = -ANGLE_W'(ai2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q <= cmd_e'(cmd_i);
      ar1_q  <= a_re_i;
      ai1_q  <= a_im_i;
      br1_q  <= b_re_i;
      bi1_q  <= b_im_i;

      cmd2_q <= cmd1_q;
      p1_q   <= ar1_q * br1_q;
      p2_q   <= ai1_q * bi1_q;
      p3_q   <= ar1_q * bi1_q;
      p4_q   <= ai1_q * br1_q;
      sr2_q  <= 33'(ar1_q) + 33'(br1_q);
      si2_q  <= 33'(ai1_q) + 33'(bi1_q);
      ar2_q  <= ar1_q;
      ai2_q  <= ai1_q;
      br2_q  <= br1_q;
      bi2_q  <= bi1_q;

      cmd3_q <= cmd2_q;
      xr3_q  <= xr_d;
      xi3_q  <= xi_d;
      yr3_q  <= yr_d;
      yi3_q  <= yi_d;
      rre3_q <= rre_d;
      rim3_q <= rim_d;
      ov3_q  <= ov_d;
      cx3_q  <= cx_d;
      cy3_q  <= cy_d;
      cz3_q  <= cz_d;
      cz3z_q <= (ar2_q == 0) && (ai2_q == 0);

      cmd4_q <= cmd3_q;
      q1_q   <= xr3_q * yr3_q;
      q2_q   <= xi3_q * yi3_q;
      q3_q   <= xi3_q * yr3_q;
      q4_q   <= xr3_q * yi3_q;
      d1_q   <= yr3_q * yr3_q;
      d2_q   <= yi3_q * yi3_q;
      rre4_q <= rre3_q;
      rim4_q <= rim3_q;
      ov4_q  <= ov3_q;
      cx4_q  <= cx3_q;
      cy4_q  <= cy3_q;
      cz4_q  <= cz3_q;
      cz4z_q <= cz3z_q;

      cmd5_q <= cmd4_q;
      nre5_q <= 65'(q1_q) + 65'(q2_q);
      nim5_q <= 65'(q3_q) - 65'(q4_q);
      den5_q <= $unsigned(d1_q) + $unsigned(d2_q);
      rre5_q <= rre4_q;
      rim5_q <= rim4_q;
      ov5_q  <= ov4_q;
      cx5_q  <= cx4_q;
      cy5_q  <= cy4_q;
      cz5_q  <= cz4_q;
      cz5z_q <= cz4z_q;

      cmd6_q <= cmd5_q;
      mre6_q <= nre5_q[64] ? 64'(-nre5_q) : nre5_q[63:0];
      mim6_q <= nim5_q[64] ? 64'(-nim5_q) : nim5_q[63:0];
      nre6_q <= nre5_q[64];
      nim6_q <= nim5_q[64];
      den6_q <= den5_q;
      dz6_q  <= (den5_q == '0) && ((cmd5_q == CMD_DIV) || (cmd5_q == CMD_PAR));
      rre6_q <= rre5_q;
      rim6_q <= rim5_q;
      ov6_q  <= ov5_q;
      cx6_q  <= cx5_q;
      cy6_q  <= cy5_q;
      cz6_q  <= cz5_q;
      cz6z_q <= cz5z_q;
    end
  end

  // Quotients that need more than DIV_STEPS bits are flagged here, so the
  // divider only has to find the low quotient bits.
  logic [CMPW-1:0] dsh;
  logic [63:0] shl_re, shl_im;

  always_comb begin
    dsh          = CMPW'(den6_q) << (DIV_STEPS - FRAC_BITS);
    shl_re       = mre6_q << FRAC_BITS;
    shl_im       = mim6_q << FRAC_BITS;
    job_o.cmd    = cmd6_q;
    job_o.ov     = ov6_q;
    job_o.dz     = dz6_q;
    job_o.res_re = rre6_q;
    job_o.res_im = rim6_q;
    job_o.re_neg = nre6_q;
    job_o.im_neg = nim6_q;
    job_o.re_big = CMPW'(mre6_q) >= dsh;
    job_o.im_big = CMPW'(mim6_q) >= dsh;
    job_o.rem_re = mre6_q >> (DIV_STEPS - FRAC_BITS);
    job_o.rem_im = mim6_q >> (DIV_STEPS - FRAC_BITS);
    job_o.low_re = shl_re[DIV_STEPS-1:0];
    job_o.low_im = shl_im[DIV_STEPS-1:0];
    job_o.den    = den6_q;
    job_o.cx     = cx6_q;
    job_o.cy     = cy6_q;
    job_o.cz     = cz6_q;
    job_o.czero  = cz6z_q;
  end

endmodule

FILE: sv/cau_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_queue
// Short FIFO of prepared jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module cau_queue import cau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  cau_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output cau_job_t job_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cau_job_t entry_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= job_i;
    end
  end

endmodule

FILE: sv/cau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_back
// Iteration pipeline: restoring division, integer square root and CORDIC
// vectoring, one step per stage, followed by result formatting.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  cau_job_t    job_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_data_o,
  output logic [1:0]  out_status_o
);

  localparam int NS  = DIV_STEPS;
  localparam int ZSH = 30 - FRAC_BITS;
  localparam logic signed [ANGLE_W-1:0] RND = ANGLE_W'((64'd1 << ZSH) >> 1);

  typedef struct packed {
    cau_job_t             job;
    logic [DIV_STEPS-1:0] q_re;
    logic [DIV_STEPS-1:0] q_im;
    logic [63:0]          sv;
    logic [63:0]          sres;
  } cau_iter_t;

  logic en;
  logic [NS:0] vld_q;
  cau_iter_t st_q [NS+1];
  cau_iter_t nx_w [NS];
  logic out_valid_q;
  logic [63:0] out_data_q;
  logic [1:0] out_status_q;

  assign en           = !out_valid_q || out_ready_i;
  assign pop_o        = en && !empty_i;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int SQ_SH = (k < SQRT_STEPS) ? 62 - 2 * k : 0;
    logic [64:0] t_re, t_im;
    logic [63:0] sb;
    logic signed [ANGLE_W-1:0] dx, dy;
    always_comb begin
      nx_w[k] = st_q[k];
      // Division: one quotient bit for each part.
      t_re = {st_q[k].job.rem_re, st_q[k].job.low_re[DIV_STEPS-1-k]};
      t_im = {st_q[k].job.rem_im, st_q[k].job.low_im[DIV_STEPS-1-k]};
      nx_w[k].q_re = {st_q[k].q_re[DIV_STEPS-2:0], t_re >= {1'b0, st_q[k].job.den}};
      nx_w[k].q_im = {st_q[k].q_im[DIV_STEPS-2:0], t_im >= {1'b0, st_q[k].job.den}};
      nx_w[k].job.rem_re = (t_re >= {1'b0, st_q[k].job.den}) ?
                           64'(t_re - {1'b0, st_q[k].job.den}) : t_re[63:0];
      nx_w[k].job.rem_im = (t_im >= {1'b0, st_q[k].job.den}) ?
                           64'(t_im - {1'b0, st_q[k].job.den}) : t_im[63:0];
      // Square root: one result bit.
      sb = st_q[k].sres + (64'd1 << SQ_SH);
      if (k < SQRT_STEPS) begin
        if (st_q[k].sv >= sb) begin
          nx_w[k].sv   = st_q[k].sv - sb;
          nx_w[k].sres = (st_q[k].sres >> 1) + (64'd1 << SQ_SH);
        end else begin
          nx_w[k].sres = st_q[k].sres >> 1;
        end
      end
      // CORDIC: one micro-rotation.
      dx = st_q[k].job.cy >>> k;
      dy = st_q[k].job.cx >>> k;
      if (k < CORDIC_STEPS) begin
        if (st_q[k].job.cy > 0) begin
          nx_w[k].job.cx = st_q[k].job.cx + dx;
          nx_w[k].job.cy = st_q[k].job.cy - dy;
          nx_w[k].job.cz = st_q[k].job.cz + atan_q30(k);
        end else begin
          nx_w[k].job.cx = st_q[k].job.cx - dx;
          nx_w[k].job.cy = st_q[k].job.cy + dy;
          nx_w[k].job.cz = st_q[k].job.cz - atan_q30(k);
        end
      end
    end
  end

  function automatic logic [32:0] div_fmt(input logic [DIV_STEPS-1:0] q,
                                          input logic neg, input logic big);
    logic [DIV_STEPS-1:0] nq;
    nq = -q;
    if (neg) begin
      if (big || (q > DIV_STEPS'(33'h080000000))) begin
        return {1'b1, 32'h80000000};
      end
      return {1'b0, nq[31:0]};
    end
    if (big || (q > DIV_STEPS'(33'h07fffffff))) begin
      return {1'b1, 32'h7fffffff};
    end
    return {1'b0, q[31:0]};
  endfunction

  cau_iter_t fin;
  logic [32:0] fre, fim, fph;
  logic signed [ANGLE_W-1:0] zr;
  logic [31:0] res_re_d, res_im_d;
  logic ov_d, dz_d;

  always_comb begin
    fin      = st_q[NS];
    fre      = div_fmt(fin.q_re, fin.job.re_neg, fin.job.re_big);
    fim      = div_fmt(fin.q_im, fin.job.im_neg, fin.job.im_big);
    zr       = (fin.job.cz + RND) >>> ZSH;
    fph      = sat_w65(65'(zr));
    res_re_d = fin.job.res_re;
    res_im_d = fin.job.res_im;
    ov_d     = fin.job.ov;
    dz_d     = 1'b0;
    case (fin.job.cmd)
      CMD_DIV, CMD_PAR: begin
        if (fin.job.dz) begin
          res_re_d = '0;
          res_im_d = '0;
          dz_d     = 1'b1;
        end else begin
          res_re_d = fre[31:0];
          res_im_d = fim[31:0];
          ov_d     = fin.job.ov | fre[32] | fim[32];
        end
      end
      CMD_MAG: begin
        res_im_d = '0;
        if (fin.sres > 64'h7fffffff) begin
          res_re_d = 32'h7fffffff;
          ov_d     = 1'b1;
        end else begin
          res_re_d = fin.sres[31:0];
        end
      end
      CMD_PHASE: begin
        res_im_d = '0;
        if (fin.job.czero) begin
          res_re_d = '0;
        end else begin
          res_re_d = fph[31:0];
          ov_d     = fph[32];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NS-1:0], !empty_i};
      out_valid_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0].job  <= job_i;
      st_q[0].q_re <= '0;
      st_q[0].q_im <= '0;
      st_q[0].sv   <= job_i.den;
      st_q[0].sres <= '0;
      for (int i = 0; i < NS; i++) begin
        st_q[i+1] <= nx_w[i];
      end
      out_data_q   <= {res_im_d, res_re_d};
      out_status_q <= dz_d ? ST_DIVZERO : (ov_d ? ST_SAT : ST_OK);
    end
  end

endmodule

FILE: sv/cau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit's result stream.
// ----------------------------------------------------------------------------
module cau_checker import cau_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_i,
  input logic [1:0]  m_axis_tuser_i
);

  // A stalled result keeps its data and status.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> (m_axis_tuser_i == ST_OK) || (m_axis_tuser_i == ST_DIVZERO) ||
                        (m_axis_tuser_i == ST_SAT))
    else $error("undefined status code");

  // A zero divisor always yields a zero result.
  a_divzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (m_axis_tuser_i == ST_DIVZERO) |-> m_axis_tdata_i == '0)
    else $error("division by zero with nonzero result");

  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_i)
    else $error("result valid during reset");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_i(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_i (m_axis_tdata_o),
  .m_axis_tuser_i (m_axis_tuser_o)
);

FILE: dv/complex_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_tb
// Drives operand transactions through the unit and checks every result against
// an in-bench fixed-point predictor or a typed-in value, with random bursts,
// gaps and receiver stalls, a long stall that fills the block, and a drain.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  localparam int FB       = 16;
  localparam int CSTEPS   = 16;
  localparam int N_RANDOM = 1800;
  localparam int LATENCY  = 42;
  localparam int LIMIT    = 400000;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    status_e     st;
  } cplx_res_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] ar, ai, br, bi;
    logic        known;
    cplx_res_t   res;
  } stim_row_t;

  logic         clk_i, rst_ni;
  logic         s_valid, s_ready, m_valid, m_ready;
  logic [127:0] s_data;
  logic [2:0]   s_user;
  logic [63:0]  m_data;
  logic [1:0]   m_user;

  cplx_res_t results_due[$];
  int        failures;
  int        cycle_cnt;
  bit        long_stall;

  complex_arithmetic_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Saturates to 32 bits and raises the overflow flag when clipping.
  function automatic logic signed [31:0] clip32(input logic signed [129:0] v,
                                               inout bit ov);
    if (v > 130'sd2147483647) begin
      ov = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -130'sd2147483648) begin
      ov = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Quotient (num << FB) / den, rounded toward zero.
  function automatic logic signed [129:0] quot_tz(input logic signed [129:0] num,
                                                  input logic [129:0] den);
    logic [129:0] mag;
    logic [129:0] q;
    mag = num[129] ? -num : num;
    q = (mag << FB) / den;
    return num[129] ? -$signed(q) : $signed(q);
  endfunction

  function automatic void cmul(input logic signed [31:0] ar, ai, br, bi,
                               output logic signed [31:0] rr, ri, inout bit ov);
    logic signed [129:0] pr, pi;
    pr = 130'(ar) * 130'(br) - 130'(ai) * 130'(bi);
    pi = 130'(ar) * 130'(bi) + 130'(ai) * 130'(br);
    rr = clip32(pr >>> FB, ov);
    ri = clip32(pi >>> FB, ov);
  endfunction

  function automatic bit cdiv(input logic signed [31:0] ar, ai, br, bi,
                              output logic signed [31:0] rr, ri, inout bit ov);
    logic [129:0] den;
    logic signed [129:0] nre, nim;
    den = 130'(130'(br) * 130'(br) + 130'(bi) * 130'(bi));
    rr = '0;
    ri = '0;
    if (den == 0) return 1'b0;
    nre = 130'(ar) * 130'(br) + 130'(ai) * 130'(bi);
    nim = 130'(ai) * 130'(br) - 130'(ar) * 130'(bi);
    rr = clip32(quot_tz(nre, den), ov);
    ri = clip32(quot_tz(nim, den), ov);
    return 1'b1;
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'h1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic signed [31:0] phase_of(input logic signed [31:0] re, im,
                                                  inout bit ov);
    logic signed [63:0] x, y, z, dx, dy;
    if (re == 0 && im == 0) return '0;
    x = re;
    y = im;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CSTEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + 64'(atan_q30(i));
      end else begin
        x = x - dx; y = y + dy; z = z - 64'(atan_q30(i));
      end
    end
    z = (z + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
    return clip32(130'(z), ov);
  endfunction

  function automatic cplx_res_t predict_result(input logic [2:0] cmd,
                                               input logic signed [31:0] ar, ai, br, bi);
    cplx_res_t r;
    bit ov, dz;
    logic signed [31:0] rr, ri, pr, pi, sr, si;
    logic [63:0] m;
    ov = 0;
    dz = 0;
    rr = 0;
    ri = 0;
    case (cmd)
      CMD_ADD: begin
        rr = clip32(130'(ar) + 130'(br), ov);
        ri = clip32(130'(ai) + 130'(bi), ov);
      end
      CMD_MUL: cmul(ar, ai, br, bi, rr, ri, ov);
      CMD_DIV: dz = !cdiv(ar, ai, br, bi, rr, ri, ov);
      CMD_PAR: begin
        cmul(ar, ai, br, bi, pr, pi, ov);
        sr = clip32(130'(ar) + 130'(br), ov);
        si = clip32(130'(ai) + 130'(bi), ov);
        dz = !cdiv(pr, pi, sr, si, rr, ri, ov);
      end
      CMD_MAG: begin
        m = isqrt(64'(64'(ar) * 64'(ar)) + 64'(64'(ai) * 64'(ai)));
        if (m > 64'h7fffffff) begin
          ov = 1;
          rr = 32'h7fffffff;
        end else begin
          rr = m[31:0];
        end
      end
      CMD_PHASE: rr = phase_of(ar, ai, ov);
      default: ;
    endcase
    r.re = rr;
    r.im = ri;
    r.st = dz ? ST_DIVZERO : (ov ? ST_SAT : ST_OK);
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1: return 32'($signed($urandom_range(0, 8)) - 4);
      2: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      3: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input logic [2:0] cmd, input logic [31:0] ar, ai, br, bi);
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= {bi, br, ai, ar};
    do @(posedge clk_i); while (!s_ready);
    if (cmd <= CMD_PHASE) results_due.push_back(predict_result(cmd, ar, ai, br, bi));
    else results_due.push_back('{re: '0, im: '0, st: ST_OK});
    @(negedge clk_i);
  endtask

  task automatic idle_sender(input int n);
    s_valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Receiver: stalls on its own pattern, with one long hold-off.
  initial begin
    m_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_stall) begin
        m_ready <= 1'b0;
        repeat (200) @(negedge clk_i);
        long_stall = 0;
      end
      m_ready <= (cycle_cnt % 700 < 250) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    cplx_res_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: result with none expected: %h %0d", $time, m_data, m_user);
        failures++;
      end else begin
        want = results_due.pop_front();
        if (m_data[31:0] !== want.re || m_data[63:32] !== want.im ||
            m_user !== want.st) begin
          $display("%0t: mismatch expected re=%h im=%h st=%0d actual re=%h im=%h st=%0d",
                   $time, want.re, want.im, want.st, m_data[31:0], m_data[63:32], m_user);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t table_rows[$];
    stim_row_t row;
    int burst;
    logic [2:0] cmd;
    logic [31:0] ar, ai, br, bi;
    failures = 0;
    cycle_cnt = 0;
    long_stall = 0;
    rst_ni = 1'b0;
    s_valid = 1'b0;
    s_user = '0;
    s_data = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows: known = 1 means the expected result is typed in.
    table_rows = '{
      '{CMD_ADD, 0, 0, 0, 0, 1, '{32'h0, 32'h0, ST_OK}},
      '{CMD_ADD, 32'h7fffffff, 32'h80000000, 1, 32'hffffffff, 1,
        '{32'h7fffffff, 32'h80000000, ST_SAT}},
      '{CMD_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, '{0, 0, ST_OK}},
      '{CMD_MUL, 32'h00010000, 0, 32'h00020000, 32'h00030000, 1,
        '{32'h00020000, 32'h00030000, ST_OK}},
      '{CMD_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, '{0, 0, ST_OK}},
      '{CMD_DIV, 32'h00050000, 32'h7, 0, 0, 1, '{32'h0, 32'h0, ST_DIVZERO}},
      '{CMD_DIV, 32'h7fffffff, 32'h80000000, 1, 0, 1,
        '{32'h7fffffff, 32'h80000000, ST_SAT}},
      '{CMD_DIV, 32'h00030000, 32'hfffc0000, 32'h00010000, 32'h00020000, 0, '{0, 0, ST_OK}},
      '{CMD_DIV, 32'hffffffff, 1, 32'h80000000, 32'h80000000, 0, '{0, 0, ST_OK}},
      '{CMD_PAR, 32'h00010000, 0, 32'hffff0000, 0, 1, '{32'h0, 32'h0, ST_DIVZERO}},
      '{CMD_PAR, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, '{0, 0, ST_OK}},
      '{CMD_PAR, 32'h00020000, 32'h00010000, 32'h00030000, 32'hffff0000, 0, '{0, 0, ST_OK}},
      '{CMD_MAG, 32'h80000000, 32'h80000000, 32'h5, 32'h9, 1,
        '{32'h7fffffff, 32'h0, ST_SAT}},
      '{CMD_MAG, 3, 4, 0, 0, 1, '{32'h5, 32'h0, ST_OK}},
      '{CMD_MAG, 32'h7fffffff, 0, 0, 0, 1, '{32'h7fffffff, 32'h0, ST_OK}},
      '{CMD_PHASE, 0, 0, 32'hffffffff, 32'hffffffff, 1, '{32'h0, 32'h0, ST_OK}},
      '{CMD_PHASE, 32'h80000000, 0, 0, 0, 0, '{0, 0, ST_OK}},
      '{CMD_PHASE, 32'h80000000, 32'hffffffff, 0, 0, 0, '{0, 0, ST_OK}},
      '{CMD_PHASE, 0, 32'h7fffffff, 0, 0, 0, '{0, 0, ST_OK}},
      '{CMD_PHASE, 32'h7fffffff, 32'h80000000, 0, 0, 0, '{0, 0, ST_OK}},
      '{3'd6, 32'h12345678, 1, 2, 3, 1, '{32'h0, 32'h0, ST_OK}},
      '{3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1,
        '{32'h0, 32'h0, ST_OK}}
    };
    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_item(row.cmd, row.ar, row.ai, row.br, row.bi);
      if (row.known) results_due[$] = row.res;
    end

    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
        if (n == 600) long_stall = 1;
        if (n == 1200) begin
          s_valid <= 1'b0;
          while (results_due.size() != 0) @(negedge clk_i);
        end
        cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
        ar = rand_operand();
        ai = rand_operand();
        br = rand_operand();
        bi = rand_operand();
        if ($urandom_range(0, 15) == 0) begin
          br = 0;
          bi = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          br = -ar;
          bi = -ai;
        end
        send_item(cmd, ar, ai, br, bi);
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
    end
    s_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/cau_pkg.sv
sv/cau_front.sv
sv/cau_queue.sv
sv/cau_back.sv
sv/complex_arithmetic_unit.sv
sv/cau_checker.sv
dv/complex_arithmetic_unit_tb.sv
